// ----- hw/rtl/lapsharp_pkg.sv -----
// Shared types, constants and sizes for the 3x3 Laplacian RGB sharpening block.
// No dependencies; the kernel and top-level files refer to it by scoped names.
package lapsharp_pkg;

  // Line store depth (longest supported row) and derived widths
  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned WREG_W    = 11;
  localparam int unsigned HREG_W    = 12;
  localparam int unsigned CFG_DW    = 12;

  // Register reset values and clamp limits
  localparam logic [WREG_W-1:0] WIDTH_RST  = WREG_W'(640);
  localparam logic [HREG_W-1:0] HEIGHT_RST = HREG_W'(480);
  localparam logic [WREG_W-1:0] WIDTH_MIN  = WREG_W'(3);
  localparam logic [WREG_W-1:0] WIDTH_MAX  = WREG_W'(MAX_WIDTH);
  localparam logic [HREG_W-1:0] HEIGHT_MIN = HREG_W'(3);

  // Register indexes
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  // Input commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Output queue
  localparam int unsigned OQ_DEPTH = 8;
  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = OQ_PTR_W + 1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // 3x3 neighborhood, indexed [row][column], [1][1] is the center
  typedef pixel_t [2:0][2:0] win_t;

  typedef struct packed {
    pixel_t px;
    logic   frame_end;
  } result_t;

  // Control and payload of the word held between accept and memory read-out
  typedef struct packed {
    logic             pix;
    logic             drn;
    logic             first;
    logic             border;
    logic             second;
    logic             frame_end;
    logic [COL_W-1:0] col;
    pixel_t           px;
  } s1_t;

endpackage

// ----- hw/rtl/lapsharp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lapsharp_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/lapsharp_kernel.sv -----
// 3x3 sharpening kernel: 9*center minus the eight neighbors, clamped to 0..255.
// Depends on lapsharp_pkg for the pixel and window types.
module lapsharp_kernel (
  input  lapsharp_pkg::win_t   win_i,
  output lapsharp_pkg::pixel_t sharp_o
);

  logic [2:0][7:0] chan_win [3][3];
  logic [2:0][7:0] chan_res;

  // Split every window pixel into its three channels (2 = red, 0 = blue)
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        chan_win[r][c] = win_i[r][c];
      end
    end
  end

  // Per channel: weighted center minus neighbor sum, then clamp
  always_comb begin
    logic [11:0] ctr9;
    logic [10:0] nsum;
    logic signed [12:0] diff;
    for (int k = 0; k < 3; k++) begin
      ctr9 = {1'b0, chan_win[1][1][k], 3'b000} + 12'(chan_win[1][1][k]);
      nsum = 11'(chan_win[0][0][k]) + 11'(chan_win[0][1][k]) + 11'(chan_win[0][2][k])
           + 11'(chan_win[1][0][k]) + 11'(chan_win[1][2][k])
           + 11'(chan_win[2][0][k]) + 11'(chan_win[2][1][k]) + 11'(chan_win[2][2][k]);
      diff = $signed({1'b0, ctr9}) - $signed({2'b00, nsum});
      if (diff < 0) begin
        chan_res[k] = 8'd0;
      end else if (diff > 13'sd255) begin
        chan_res[k] = 8'd255;
      end else begin
        chan_res[k] = diff[7:0];
      end
    end
  end

  assign sharp_o = chan_res;

endmodule

// ----- hw/rtl/laplacian_sharpen_3x3_rgb.sv -----
// Top level: streaming 3x3 Laplacian sharpening of raster-order RGB888.
// Depends on lapsharp_pkg, lapsharp_ram (two line stores) and lapsharp_kernel.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+-------------------------------------
//   in      | sink      | in_valid_i / in_stall_o  | command_i, red/green/blue_in_i
//   out     | source    | out_valid_o / out_stall_i| red/green/blue_out_o, frame_end_o
//   cfg     | sink      | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// One word is accepted per cycle while in_stall_o is low. It is registered into stage 1
// as the line stores are read; its results then enter the output queue. The last pixel
// of every row but the first yields two results, so the 8-entry output queue sets the
// stall: in_stall_o rises when the queue plus results in flight leave under two free
// slots. Reset clears counters, window and queue; line store contents stay undefined.
module laplacian_sharpen_3x3_rgb (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           command_i,
  input  logic [7:0]                     red_in_i,
  input  logic [7:0]                     green_in_i,
  input  logic [7:0]                     blue_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     red_out_o,
  output logic [7:0]                     green_out_o,
  output logic [7:0]                     blue_out_o,
  output logic                           frame_end_o,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [lapsharp_pkg::CFG_DW-1:0] cfg_data_i
);

  localparam int unsigned COL_W    = lapsharp_pkg::COL_W;
  localparam int unsigned HREG_W   = lapsharp_pkg::HREG_W;
  localparam int unsigned WREG_W   = lapsharp_pkg::WREG_W;
  localparam int unsigned OQ_PTR_W = lapsharp_pkg::OQ_PTR_W;
  localparam int unsigned OQ_CNT_W = lapsharp_pkg::OQ_CNT_W;

  // Configuration registers
  logic [WREG_W-1:0] width_q;
  logic [HREG_W-1:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= lapsharp_pkg::WIDTH_RST;
      height_q <= lapsharp_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      if (cfg_index_i == lapsharp_pkg::CFG_WIDTH) begin
        width_q <= cfg_data_i[WREG_W-1:0];
      end else begin
        height_q <= cfg_data_i[HREG_W-1:0];
      end
    end
  end

  // Effective frame size
  logic [WREG_W-1:0] w_eff;
  logic [COL_W-1:0]  w_m1;
  logic [HREG_W-1:0] h_eff;
  logic [HREG_W-1:0] h_m1;

  always_comb begin
    if (width_q < lapsharp_pkg::WIDTH_MIN) begin
      w_eff = lapsharp_pkg::WIDTH_MIN;
    end else if (width_q > lapsharp_pkg::WIDTH_MAX) begin
      w_eff = lapsharp_pkg::WIDTH_MAX;
    end else begin
      w_eff = width_q;
    end
    h_eff = (height_q < lapsharp_pkg::HEIGHT_MIN) ? lapsharp_pkg::HEIGHT_MIN : height_q;
    w_m1  = COL_W'(w_eff - WREG_W'(1));
    h_m1  = h_eff - HREG_W'(1);
  end

  // Position counters
  logic [COL_W-1:0]  col_q, col_d;
  logic [HREG_W-1:0] row_q, row_d;
  logic [COL_W-1:0]  drain_q, drain_d;
  logic              draining;
  logic              accept;
  logic              last_col;
  logic              last_drain;
  lapsharp_pkg::s1_t s1_q, s1_d;

  assign draining   = (row_q >= h_eff);
  assign accept     = in_valid_i && !in_stall_o;
  assign last_col   = (col_q >= w_m1);
  assign last_drain = (drain_q >= w_m1);

  // Counter update and stage 1 word at accept
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    drain_d = drain_q;
    s1_d    = '0;
    s1_d.col = col_q;
    s1_d.px  = {red_in_i, green_in_i, blue_in_i};
    if (accept && command_i == lapsharp_pkg::CMD_PIXEL && !draining) begin
      s1_d.pix    = 1'b1;
      s1_d.first  = (row_q != '0) && (col_q != '0);
      s1_d.border = (row_q == HREG_W'(1)) || (col_q == COL_W'(1));
      s1_d.second = last_col && (row_q != '0);
      if (last_col) begin
        col_d = '0;
        if (row_q >= h_m1) begin
          row_d   = h_eff;
          drain_d = '0;
        end else begin
          row_d = row_q + HREG_W'(1);
        end
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end else if (accept && command_i == lapsharp_pkg::CMD_DRAIN && draining) begin
      s1_d.drn       = 1'b1;
      s1_d.frame_end = last_drain;
      if (last_drain) begin
        row_d   = '0;
        col_d   = '0;
        drain_d = '0;
      end else begin
        drain_d = drain_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= '0;
      s1_q    <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      drain_q <= drain_d;
      s1_q    <= s1_d;
    end
  end

  // Line stores: prev holds the row above, prev2 the row before it
  lapsharp_pkg::pixel_t above, above2;
  logic [COL_W-1:0]     prev_raddr;

  assign prev_raddr = (command_i == lapsharp_pkg::CMD_DRAIN) ? drain_q : col_q;

  lapsharp_ram #(
    .WIDTH ($bits(lapsharp_pkg::pixel_t)),
    .DEPTH (lapsharp_pkg::MAX_WIDTH)
  ) u_prev_row (
    .clk_i   (clk_i),
    .we_i    (s1_q.pix),
    .waddr_i (s1_q.col),
    .wdata_i (s1_q.px),
    .raddr_i (prev_raddr),
    .rdata_o (above)
  );

  lapsharp_ram #(
    .WIDTH ($bits(lapsharp_pkg::pixel_t)),
    .DEPTH (lapsharp_pkg::MAX_WIDTH)
  ) u_prev2_row (
    .clk_i   (clk_i),
    .we_i    (s1_q.pix),
    .waddr_i (s1_q.col),
    .wdata_i (above),
    .raddr_i (col_q),
    .rdata_o (above2)
  );

  // Window shift: new right column comes from the line stores and the pixel
  lapsharp_pkg::win_t win_q, win_d;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r][0] = win_q[r][1];
      win_d[r][1] = win_q[r][2];
    end
    win_d[0][2] = above2;
    win_d[1][2] = above;
    win_d[2][2] = s1_q.px;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_q.pix) begin
      win_q <= win_d;
    end
  end

  lapsharp_pkg::pixel_t sharp;

  lapsharp_kernel u_kernel (
    .win_i   (win_d),
    .sharp_o (sharp)
  );

  // Results of the stage 1 word
  lapsharp_pkg::result_t slot0, slot1;
  logic [1:0]            push_n;

  always_comb begin
    slot0  = '0;
    slot1  = '0;
    push_n = 2'd0;
    if (s1_q.drn) begin
      slot0.px        = above;
      slot0.frame_end = s1_q.frame_end;
      push_n          = 2'd1;
    end else if (s1_q.pix) begin
      slot0.px = s1_q.border ? win_d[1][1] : sharp;
      slot1.px = win_d[1][2];
      if (s1_q.first && s1_q.second) begin
        push_n = 2'd2;
      end else if (s1_q.first || s1_q.second) begin
        push_n = 2'd1;
        if (!s1_q.first) begin
          slot0.px = win_d[1][2];
        end
      end
    end
  end

  // Output queue
  lapsharp_pkg::result_t oq_q [lapsharp_pkg::OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   head_q, tail_q, tail_p1;
  logic [OQ_CNT_W-1:0]   count_q;
  logic                  pop;

  assign tail_p1 = tail_q + OQ_PTR_W'(1);
  assign pop     = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      oq_q[tail_q] <= slot0;
    end
    if (push_n == 2'd2) begin
      oq_q[tail_p1] <= slot1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      tail_q  <= tail_q + OQ_PTR_W'(push_n);
      head_q  <= head_q + OQ_PTR_W'(pop);
      count_q <= count_q + OQ_CNT_W'(push_n) - OQ_CNT_W'(pop);
    end
  end

  // Stall while fewer than two slots remain beyond what is already owed
  assign in_stall_o = (count_q + OQ_CNT_W'(push_n)) >
                      OQ_CNT_W'(lapsharp_pkg::OQ_DEPTH - 2);

  assign out_valid_o = (count_q != '0);
  assign red_out_o   = oq_q[head_q].px.red;
  assign green_out_o = oq_q[head_q].px.green;
  assign blue_out_o  = oq_q[head_q].px.blue;
  assign frame_end_o = oq_q[head_q].frame_end;

  // Checks
  a_oq_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= OQ_CNT_W'(lapsharp_pkg::OQ_DEPTH))
    else $error("output queue overflow");

  a_second_follows_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q.second |-> s1_q.first)
    else $error("row end result without interior result");

  a_end_only_on_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q.frame_end |-> s1_q.drn)
    else $error("frame end flagged on a non-drain word");

  a_one_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_q.drn |-> (!s1_q.pix && push_n == 2'd1))
    else $error("drain word must yield exactly one result");

endmodule
